// ===== design/rllf_pkg.sv =====
// shared types, constants and conversion helpers for the rgb led linear fader
`timescale 1ns / 1ps

package rllf_pkg;

  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned RATE_W     = 17;
  localparam int unsigned COLOUR_W   = 8;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned PROD_W     = RATE_W + MS_W + 1;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 16'd32768;

  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RAMP = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MUL,
    ST_ADD,
    ST_TICK_END,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic              start;
    logic [MS_W-1:0]   dividend;
    logic [MS_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [MS_W-1:0]   quotient;
  } div_rsp_t;

  // floor(c * 32768 / 255) as 128c + floor(128c / 255)
  function automatic logic [LEVEL_W-1:0] colour_to_level(input logic [COLOUR_W-1:0] c);
    logic [16:0] x;
    logic [16:0] q;
    x = {2'b00, c, 7'b0};
    q = (x + (x >> 8) + 17'd1) >> 8;
    return LEVEL_W'(x + q);
  endfunction

  // (level * 255) >> 15
  function automatic logic [COLOUR_W-1:0] level_to_colour(input logic [LEVEL_W-1:0] lv);
    logic [23:0] p;
    p = {lv, 8'b0} - {8'b0, lv};
    return p[22:15];
  endfunction

endpackage

// ===== design/rgb_led_linear_fader.sv =====
// top level of the three-channel linear led fader with its sequencer and state
`timescale 1ns / 1ps
// sequence: a tick runs multiply and add for each channel, then the deadline check; set, ramp of zero
//   and unused codes go straight to the result; a ramp runs three serial divides, one per channel
// throughput: one item at a time, the next one accepted only once the result has loaded into the
//   output register; a full, untaken result register holds the sequencer
// the output register frees the block to take the next item while a result waits
// reset: asynchronous active low; levels, targets, rates, time and flags clear to zero

module rgb_led_linear_fader (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // red [7:0], green [15:8], blue [23:16], ramp_ms [39:24], elapsed_ms [55:40]
  input  logic [rllf_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // command [1:0]
  input  logic [rllf_pkg::CMD_W-1:0]     s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // red_out [7:0], green_out [15:8], blue_out [23:16], changed [24], forced [25],
  // zero [31:26]
  output logic [rllf_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import rllf_pkg::*;

  state_e state_q, state_d;

  // fader state
  logic [LEVEL_W-1:0]   level_q  [NUM_CH];
  logic [LEVEL_W-1:0]   prev_q   [NUM_CH];
  logic [LEVEL_W-1:0]   target_q [NUM_CH];
  logic [RATE_W-1:0]    rate_q   [NUM_CH];
  logic [TIME_BITS-1:0] time_q;
  logic [TIME_BITS-1:0] deadline_q;
  logic                 force_q;

  // latched item
  logic [CMD_W-1:0]     cmd_q;
  logic [LEVEL_W-1:0]   req_q [NUM_CH];
  logic [MS_W-1:0]      ramp_q;
  logic [MS_W-1:0]      elapsed_q;

  // working registers
  logic [1:0]           ch_q;
  logic                 neg_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                 forced_q;

  // output register
  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  // control
  logic s_ready;
  logic div_go;
  logic out_load;
  logic is_instant;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // datapath helpers
  logic [RATE_W-1:0]         diff;
  logic [RATE_W-1:0]         diff_mag;
  logic [RATE_W-1:0]         quo_ext;
  logic signed [PROD_W:0]    sum;
  logic [LEVEL_W-1:0]        sat_level;
  logic                      changed;
  logic [TIME_BITS-1:0]      ramp_ext;
  logic [TIME_BITS-1:0]      elapsed_ext;

  assign is_instant = (cmd_q == CMD_SET) || (cmd_q == CMD_RAMP && ramp_q == '0);
  assign ramp_ext    = {{(TIME_BITS-MS_W){1'b0}}, ramp_q};
  assign elapsed_ext = {{(TIME_BITS-MS_W){1'b0}}, elapsed_q};

  // signed distance to the new colour and its magnitude for the divider
  assign diff     = {1'b0, req_q[ch_q]} - {1'b0, level_q[ch_q]};
  assign diff_mag = diff[RATE_W-1] ? (~diff + 1'b1) : diff;
  assign quo_ext  = {1'b0, div_rsp.quotient};

  // level plus the registered step, clamped to the level range
  assign sum = $signed({{(PROD_W-LEVEL_W+1){1'b0}}, level_q[ch_q]}) +
               $signed({prod_q[PROD_W-1], prod_q});
  always_comb begin
    if (sum[PROD_W]) begin
      sat_level = '0;
    end else if (sum > $signed({{(PROD_W-LEVEL_W+1){1'b0}}, LEVEL_FULL})) begin
      sat_level = LEVEL_FULL;
    end else begin
      sat_level = sum[LEVEL_W-1:0];
    end
  end

  assign changed = (level_q[0] != prev_q[0]) || (level_q[1] != prev_q[1]) ||
                   (level_q[2] != prev_q[2]);

  // shared divider for the ramp rates of all three channels
  assign div_req.start    = div_go;
  assign div_req.dividend = diff_mag[MS_W-1:0];
  assign div_req.divisor  = ramp_q;

  rllf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (is_instant) begin
          state_d = ST_FINISH;
        end else if (cmd_q == CMD_RAMP) begin
          state_d = ST_DIV_START;
        end else if (cmd_q == CMD_TICK) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_d = (ch_q == 2'd2) ? ST_FINISH : ST_DIV_START;
        end
      end
      ST_MUL: state_d = ST_ADD;
      ST_ADD: state_d = (ch_q == 2'd2) ? ST_TICK_END : ST_MUL;
      ST_TICK_END: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_ready  = 1'b0;
    div_go   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE:      s_ready  = 1'b1;
      ST_DIV_START: div_go   = 1'b1;
      ST_FINISH:    out_load = !m_valid_q || m_axis_tready_i;
      default: begin
        s_ready = 1'b0;
      end
    endcase
  end

  // control and fader state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_valid_q  <= 1'b0;
      ch_q       <= '0;
      neg_q      <= 1'b0;
      prod_q     <= '0;
      time_q     <= '0;
      deadline_q <= '0;
      force_q    <= 1'b0;
      forced_q   <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        level_q[i]  <= '0;
        prev_q[i]   <= '0;
        target_q[i] <= '0;
        rate_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;

      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_DISPATCH: begin
          ch_q     <= '0;
          forced_q <= 1'b0;
          if (is_instant) begin
            for (int i = 0; i < NUM_CH; i++) begin
              level_q[i]  <= req_q[i];
              target_q[i] <= req_q[i];
              rate_q[i]   <= '0;
            end
            deadline_q <= time_q;
            force_q    <= 1'b1;
          end else if (cmd_q == CMD_RAMP) begin
            for (int i = 0; i < NUM_CH; i++) begin
              target_q[i] <= req_q[i];
            end
            deadline_q <= time_q + ramp_ext;
          end else if (cmd_q == CMD_TICK) begin
            time_q <= time_q + elapsed_ext;
          end
        end
        ST_DIV_START: begin
          neg_q <= diff[RATE_W-1];
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            rate_q[ch_q] <= neg_q ? (~quo_ext + 1'b1) : quo_ext;
            ch_q         <= ch_q + 2'd1;
          end
        end
        ST_MUL: begin
          prod_q <= $signed(rate_q[ch_q]) * $signed({1'b0, elapsed_q});
        end
        ST_ADD: begin
          prev_q[ch_q]  <= level_q[ch_q];
          level_q[ch_q] <= sat_level;
          ch_q          <= ch_q + 2'd1;
        end
        ST_TICK_END: begin
          // at or past the deadline the ramp ends on the targets
          if (time_q >= deadline_q) begin
            for (int i = 0; i < NUM_CH; i++) begin
              rate_q[i]  <= '0;
              level_q[i] <= target_q[i];
            end
          end
          forced_q <= force_q;
          force_q  <= 1'b0;
        end
        default: begin
          ch_q <= ch_q;
        end
      endcase
    end
  end

  // item capture and output payload
  always_ff @(posedge clk_i) begin
    if (s_ready && s_axis_tvalid_i) begin
      cmd_q     <= s_axis_tuser_i;
      req_q[0]  <= colour_to_level(s_axis_tdata_i[7:0]);
      req_q[1]  <= colour_to_level(s_axis_tdata_i[15:8]);
      req_q[2]  <= colour_to_level(s_axis_tdata_i[23:16]);
      ramp_q    <= s_axis_tdata_i[39:24];
      elapsed_q <= s_axis_tdata_i[55:40];
    end
    if (out_load) begin
      m_data_q <= {6'b0, forced_q, changed, level_to_colour(level_q[2]),
                   level_to_colour(level_q[1]), level_to_colour(level_q[0])};
    end
  end

  assign s_axis_tready_o = s_ready;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

// ===== design/rllf_div.sv =====
// serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module rllf_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rllf_pkg::div_req_t req_i,
  output rllf_pkg::div_rsp_t rsp_o
);
  import rllf_pkg::*;

  logic [MS_W-1:0] rem_q, rem_d;
  logic [MS_W-1:0] quo_q, quo_d;
  logic [MS_W-1:0] div_q, div_d;
  logic [3:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [MS_W:0]   shifted;
  logic [MS_W:0]   diff;

  always_comb begin
    shifted = {rem_q, quo_q[MS_W-1]};
    diff    = shifted - {1'b0, div_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      div_d  = req_i.divisor;
      cnt_d  = 4'd15;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[MS_W]) begin
        rem_d = diff[MS_W-1:0];
        quo_d = {quo_q[MS_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[MS_W-1:0];
        quo_d = {quo_q[MS_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== tb/tb_top.sv =====
// self-checking stream testbench for the rgb led linear fader
`timescale 1ns / 1ps

module tb_top;
  import rllf_pkg::*;

  // command code that the block does not decode
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1050;
  localparam int RESET_CYCLES = 11;
  // receiver back-pressure stretch, long enough to fill the output register
  localparam int HOLD_CYCLES  = 400;
  // quiet cycles allowed: the hold above plus a slow ramp item, many times over
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 120;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    logic [MS_W-1:0]     ramp_ms;
    logic [MS_W-1:0]     elapsed_ms;
  } fade_cmd_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [CMD_W-1:0]      s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  // stimulus not yet offered, and result words still owed by the block
  fade_cmd_t             cmds_pending [$];
  logic [OUT_DATA_W-1:0] colours_due [$];
  fade_cmd_t             on_bus;
  fade_cmd_t             nxt_cmd;

  // shadow of the fader state
  int                    lvl [NUM_CH];
  int                    lvl_prev [NUM_CH];
  int                    lvl_goal [NUM_CH];
  int                    step_per_ms [NUM_CH];
  logic [TIME_BITS-1:0]  now_ms;
  logic [TIME_BITS-1:0]  due_ms;
  bit                    force_seen;

  int sent_cnt;
  int rx_cnt;
  int phase_a;
  int phase_b;
  int hold_left;
  bit hold_armed;
  int quiet;
  int err_cnt;
  int n_tick, n_set, n_ramp, n_unused, n_forced, n_changed;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  rgb_led_linear_fader i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  // 8-bit colour to 16-bit level, floor(c * 32768 / 255)
  function automatic int lvl_of(input logic [COLOUR_W-1:0] c);
    return (int'(c) * 32768) / 255;
  endfunction

  // advance the shadow state by one command and return the result word it owes
  function automatic logic [OUT_DATA_W-1:0] next_colours(input fade_cmd_t it);
    int                    req [NUM_CH];
    longint                acc;
    bit                    moved;
    bit                    frc;
    logic [OUT_DATA_W-1:0] word;
    req[0] = lvl_of(it.red);
    req[1] = lvl_of(it.green);
    req[2] = lvl_of(it.blue);
    frc = 1'b0;
    moved = 1'b0;
    word = '0;
    if (it.cmd == CMD_SET || (it.cmd == CMD_RAMP && it.ramp_ms == '0)) begin
      // instant jump, ramp of zero lands here too
      for (int i = 0; i < NUM_CH; i++) begin
        lvl[i] = req[i];
        lvl_goal[i] = req[i];
        step_per_ms[i] = 0;
      end
      due_ms = now_ms;
      force_seen = 1'b1;
      n_set++;
    end else if (it.cmd == CMD_RAMP) begin
      // signed int division truncates toward zero
      for (int i = 0; i < NUM_CH; i++) begin
        lvl_goal[i] = req[i];
        step_per_ms[i] = (req[i] - lvl[i]) / int'(it.ramp_ms);
      end
      due_ms = now_ms + TIME_BITS'(it.ramp_ms);
      n_ramp++;
    end else if (it.cmd == CMD_TICK) begin
      for (int i = 0; i < NUM_CH; i++) begin
        acc = longint'(lvl[i]) + longint'(step_per_ms[i]) * longint'(it.elapsed_ms);
        if (acc < 0) begin
          acc = 0;
        end
        if (acc > 32768) begin
          acc = 32768;
        end
        lvl_prev[i] = lvl[i];
        lvl[i] = int'(acc);
      end
      now_ms = now_ms + TIME_BITS'(it.elapsed_ms);
      if (now_ms >= due_ms) begin
        for (int i = 0; i < NUM_CH; i++) begin
          step_per_ms[i] = 0;
          lvl[i] = lvl_goal[i];
        end
      end
      frc = force_seen;
      force_seen = 1'b0;
      n_tick++;
    end else begin
      n_unused++;
    end
    for (int i = 0; i < NUM_CH; i++) begin
      word[i*8 +: 8] = 8'((lvl[i] * 255) >> 15);
      if (lvl[i] != lvl_prev[i]) begin
        moved = 1'b1;
      end
    end
    word[24] = moved;
    word[25] = frc;
    n_forced += frc;
    n_changed += moved;
    return word;
  endfunction

  task automatic add_cmd(input logic [CMD_W-1:0] cmd, input logic [7:0] r,
                         input logic [7:0] g, input logic [7:0] b,
                         input logic [MS_W-1:0] ramp, input logic [MS_W-1:0] el);
    fade_cmd_t it;
    it.cmd = cmd;
    it.red = r;
    it.green = g;
    it.blue = b;
    it.ramp_ms = ramp;
    it.elapsed_ms = el;
    cmds_pending.push_back(it);
  endtask

  // colours biased toward the ends of the range
  function automatic logic [7:0] pick_colour();
    int p;
    p = $urandom_range(99);
    if (p < 12) begin
      return 8'd0;
    end else if (p < 24) begin
      return 8'd255;
    end
    return 8'($urandom_range(255));
  endfunction

  // sender: holds an offered item until it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
      sent_cnt <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        colours_due.push_back(next_colours(on_bus));
        sent_cnt <= sent_cnt + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (cmds_pending.size() != 0 && $urandom_range(99) >=
            (sent_cnt < phase_a ? 21 : (sent_cnt < phase_b ? 54 : 0))) begin
          nxt_cmd = cmds_pending.pop_front();
          on_bus   <= nxt_cmd;
          s_tvalid <= 1'b1;
          s_tdata  <= {nxt_cmd.elapsed_ms, nxt_cmd.ramp_ms, nxt_cmd.blue,
                       nxt_cmd.green, nxt_cmd.red};
          s_tuser  <= nxt_cmd.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off at the start of the no-idle phase
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && rx_cnt >= phase_b) begin
      hold_left  <= HOLD_CYCLES;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_left == 0) && ($urandom_range(99) >=
                  (rx_cnt < phase_a ? 54 : (rx_cnt < phase_b ? 21 : 0)));
    end
  end

  // result checker and watchdog
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_cnt <= 0;
      quiet  <= 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("timeout: no item moved for %0d cycles, %0d results owed",
                 quiet, colours_due.size());
        $display("tb_top NOT OK");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
      if (m_tvalid && m_tready) begin
        rx_cnt <= rx_cnt + 1;
        if (colours_due.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("unexpected result %h at result %0d", m_tdata, rx_cnt);
          end
        end else if (m_tdata !== colours_due[0]) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("result %0d: want r=%0d g=%0d b=%0d chg=%0b frc=%0b pad=%h",
                     rx_cnt, colours_due[0][7:0], colours_due[0][15:8],
                     colours_due[0][23:16], colours_due[0][24], colours_due[0][25],
                     colours_due[0][31:26]);
            $display("           got  r=%0d g=%0d b=%0d chg=%0b frc=%0b pad=%h",
                     m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[24],
                     m_tdata[25], m_tdata[31:26]);
          end
          void'(colours_due.pop_front());
        end else begin
          void'(colours_due.pop_front());
        end
      end
    end
  end

  initial begin
    logic [MS_W-1:0] rmp;
    int              base;
    int              p;
    int              n;
    for (int i = 0; i < NUM_CH; i++) begin
      lvl[i] = 0;
      lvl_prev[i] = 0;
      lvl_goal[i] = 0;
      step_per_ms[i] = 0;
    end
    now_ms = '0;
    due_ms = '0;
    force_seen = 1'b0;
    err_cnt = 0;
    {n_tick, n_set, n_ramp, n_unused, n_forced, n_changed} = '0;

    // directed part
    add_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000);   // first tick snaps to zero
    add_cmd(CMD_UNUSED, 8'hff, 8'hff, 8'hff, 16'hffff, 16'hffff);
    add_cmd(CMD_SET, 8'hff, 8'hff, 8'hff, 16'h0000, 16'h0000);    // full level held exactly
    add_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000);   // force flag consumed
    add_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0001);
    add_cmd(CMD_RAMP, 8'h00, 8'h00, 8'h00, 16'hffff, 16'h0000);   // slowest fade down
    add_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 16'd1000);
    add_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 16'hffff);   // crosses the deadline
    add_cmd(CMD_RAMP, 8'h80, 8'h01, 8'hfe, 16'h0000, 16'h1234);   // ramp of zero is instant
    add_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000);
    add_cmd(CMD_RAMP, 8'hff, 8'h00, 8'h80, 16'h0001, 16'h0000);
    add_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 16'hffff);   // overshoot saturates
    add_cmd(CMD_SET, 8'h00, 8'hff, 8'h00, 16'hffff, 16'hffff);
    add_cmd(CMD_RAMP, 8'hff, 8'h00, 8'hff, 16'h0003, 16'h0000);
    add_cmd(CMD_TICK, 8'h55, 8'haa, 8'h55, 16'haaaa, 16'h0001);
    add_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0001);
    add_cmd(CMD_UNUSED, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000);
    add_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0001);
    add_cmd(CMD_RAMP, 8'h01, 8'h02, 8'h03, 16'hffff, 16'h0000);
    add_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 16'hfffe);
    add_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0001);
    add_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'h5555, 16'h5555);
    add_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'haaaa, 16'haaaa);

    // random part: mostly ramps followed by ticks that walk toward the deadline
    base = cmds_pending.size();
    while (cmds_pending.size() < base + RANDOM_ITEMS) begin
      p = $urandom_range(99);
      if (p < 55) begin
        n = $urandom_range(99);
        rmp = n < 70 ? MS_W'($urandom_range(300, 1)) :
              (n < 90 ? MS_W'($urandom_range(65535, 1)) : '0);
        add_cmd(CMD_RAMP, pick_colour(), pick_colour(), pick_colour(), rmp,
                MS_W'($urandom));
        n = $urandom_range(8, 1);
        for (int k = 0; k < n; k++) begin
          add_cmd(CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom), MS_W'($urandom),
                  $urandom_range(99) < 80 ? MS_W'($urandom_range(int'(rmp) / 3 + 1, 0))
                                          : MS_W'($urandom));
        end
      end else if (p < 70) begin
        add_cmd(CMD_SET, pick_colour(), pick_colour(), pick_colour(), MS_W'($urandom),
                MS_W'($urandom));
        n = $urandom_range(3, 1);
        for (int k = 0; k < n; k++) begin
          add_cmd(CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom), MS_W'($urandom),
                  MS_W'($urandom_range(50)));
        end
      end else if (p < 78) begin
        add_cmd(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), MS_W'($urandom),
                MS_W'($urandom));
      end else begin
        add_cmd(CMD_W'($urandom_range(3)), 8'($urandom), 8'($urandom), 8'($urandom),
                MS_W'($urandom), MS_W'($urandom));
      end
    end
    phase_a = cmds_pending.size() / 3;
    phase_b = 2 * cmds_pending.size() / 3;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmds_pending.size() != 0 || s_tvalid) @(posedge clk_i);
    while (colours_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d ticks, %0d instant sets, %0d ramps, %0d unused codes",
             n_tick, n_set, n_ramp, n_unused);
    $display("results with force flag %0d, with change flag %0d, failures %0d",
             n_forced, n_changed, err_cnt);
    if (err_cnt == 0 && colours_due.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
